>>> sv/laplacian_highpass_3x3_unit_assert.svh
// ----------------------------------------------------------------------------
// Laplacian high-pass assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_HIGHPASS_3X3_UNIT_ASSERT_SVH
`define LAPLACIAN_HIGHPASS_3X3_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LHP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lhp_pkg.sv
// ----------------------------------------------------------------------------
// Laplacian high-pass package
// Shared widths, register codes, reset values and the position flag bundle.
// ----------------------------------------------------------------------------
package lhp_pkg;

  localparam int PIX_W         = 8;
  localparam int WIDTH_REG_W   = 11;
  localparam int HEIGHT_REG_W  = 12;
  localparam int CFG_DATA_W    = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int ROW_W         = 13;   // input row runs to height+1 while draining
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int SUM_W         = 13;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 12'd480;

  // (sum + 2032) >> 4 is sum/16 centered on 127
  localparam logic signed [SUM_W-1:0] ROUND_OFFSET = 13'sd2032;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lhp_reg_t;

  // Where an output position sits in the frame
  typedef struct packed {
    logic emit;
    logic up;
    logic down;
    logic left;
    logic right;
    logic eor;
    logic eof;
  } lhp_pos_t;

endpackage

>>> sv/laplacian_highpass_3x3_unit.sv
// ----------------------------------------------------------------------------
// Laplacian high-pass 3x3 filter
// Streaming 3x3 Laplacian on raster-ordered grayscale pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Feed pixels in raster order on the s_axis channel, one beat per pixel,
//   with s_axis_tuser low. After the last pixel of a frame, send image_width+1
//   drain beats (tuser high, or any beat once the frame's rows are in); a
//   drain beat sent while pixels are still expected is dropped.
//   Each result beat on m_axis carries the filtered pixel in tdata, the
//   end-of-row flag in tlast and the end-of-frame flag in tuser.
//   A result belongs to the pixel accepted image_width+1 beats earlier; it
//   passes stage 1, stage 2 and the output register before it is valid on
//   m_axis. Throughput: one beat per cycle on both channels unless m_axis stalls.
//   Write cfg registers only while idle; a write restarts the frame counters.
//   Reset clears counters and restores width 640, height 480; row memories
//   need no clearing since taps outside the frame are masked.
//   When m_axis stalls, a skid register takes one more result, then
//   s_axis_tready drops and the whole pipe holds.
// ----------------------------------------------------------------------------
`include "laplacian_highpass_3x3_unit_assert.svh"

module laplacian_highpass_3x3_unit #(
  parameter int MAX_WIDTH = lhp_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input pixels
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel_in
  input  logic                            s_axis_tuser,   // [0] flush
  // filtered pixels
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] pixel_out
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser,   // [0] end_of_frame
  // configuration
  input  logic                            cfg_we,
  input  logic [lhp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lhp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                      en;         // pipe advance
  logic                      accept;
  logic                      take;       // beat enters the pipe
  logic                      drain;
  logic [CW-1:0]             col;
  lhp_pkg::lhp_pos_t         pos;

  // stage 1: accepted beat, row memory read in flight
  logic                      s1_valid;
  logic [lhp_pkg::PIX_W-1:0] s1_pix;
  logic [CW-1:0]             s1_addr;
  lhp_pkg::lhp_pos_t         s1_pos;

  // stage 2: window holds this beat's neighborhood
  logic                      s2_valid;
  lhp_pkg::lhp_pos_t         s2_pos;

  logic [lhp_pkg::PIX_W-1:0] older_q;
  logic [lhp_pkg::PIX_W-1:0] newer_q;
  logic [lhp_pkg::PIX_W-1:0] res_pix;
  logic                      new_res;

  // skid register behind the output register
  logic                      skid_valid;
  logic [lhp_pkg::PIX_W-1:0] skid_pix;
  logic                      skid_eor;
  logic                      skid_eof;

  // hold everything while the skid register is occupied
  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  lhp_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .flush     (s_axis_tuser),
    .take      (take),
    .drain     (drain),
    .col       (col),
    .pos       (pos)
  );

  lhp_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (col),
    .wr_en   (en && s1_valid),
    .wr_addr (s1_addr),
    .wr_pix  (s1_pix),
    .older_q (older_q),
    .newer_q (newer_q)
  );

  lhp_window u_window (
    .clk      (clk),
    .shift    (en && s1_valid),
    .older_q  (older_q),
    .newer_q  (newer_q),
    .incoming (s1_pix),
    .pos      (s2_pos),
    .pixel    (res_pix)
  );

  // advance stage 1 and stage 2 together; drain beats carry a zero pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= take;
      s2_valid <= s1_valid && s1_pos.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        s1_pix  <= drain ? '0 : s_axis_tdata[lhp_pkg::PIX_W-1:0];
        s1_addr <= col;
        s1_pos  <= pos;
      end
      s2_pos <= s1_pos;
    end
  end

  assign new_res = en && s2_valid;

  // output register plus skid: a stalled result parks one new beat in skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        m_axis_tdata <= skid_pix;
        m_axis_tlast <= skid_eor;
        m_axis_tuser <= skid_eof;
        skid_valid   <= 1'b0;
      end
    end else if (new_res) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tdata  <= res_pix;
        m_axis_tlast  <= s2_pos.eor;
        m_axis_tuser  <= s2_pos.eof;
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_pix   <= res_pix;
        skid_eor   <= s2_pos.eor;
        skid_eof   <= s2_pos.eof;
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // skid only fills behind a held output beat
  `LHP_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, m_axis_tvalid, "skid full with output empty")
  // frame end always coincides with row end
  `LHP_ASSERT_SAME(a_eof_is_eor, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "end of frame without end of row")
  // a stalled pipe keeps its stage occupancy
  `LHP_ASSERT_NEXT(a_stall_holds, clk, rst, !en && !m_axis_tready, $stable(s1_valid) && $stable(s2_valid), "pipe moved while stalled")

endmodule

>>> sv/lhp_ctrl.sv
// ----------------------------------------------------------------------------
// Laplacian high-pass position control
// Configuration registers plus the input and output position counters.
// ----------------------------------------------------------------------------
module lhp_ctrl #(
  parameter int MAX_WIDTH = lhp_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int EW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lhp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lhp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic                            flush,
  output logic                            take,
  output logic                            drain,
  output logic [CW-1:0]                   col,
  output lhp_pkg::lhp_pos_t               pos
);

  logic [lhp_pkg::WIDTH_REG_W-1:0]  cfg_width;
  logic [lhp_pkg::HEIGHT_REG_W-1:0] cfg_height;
  logic [CW-1:0]                    in_col;
  logic [lhp_pkg::ROW_W-1:0]        in_row;
  logic [CW-1:0]                    out_col;
  logic [lhp_pkg::HEIGHT_REG_W-1:0] out_row;

  logic [EW-1:0]                    eff_w;
  logic [lhp_pkg::HEIGHT_REG_W-1:0] eff_h;
  logic                             col_last;

  // clamp width to 3..MAX_WIDTH, height 0 acts as 1
  always_comb begin
    if (cfg_width < 11'd3) begin
      eff_w = EW'(3);
    end else if ({2'b00, cfg_width} > 13'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_width);
    end
    eff_h = (cfg_height == '0) ? 12'd1 : cfg_height;
  end

  assign drain    = in_row >= {1'b0, eff_h};
  assign take     = accept && (drain || !flush);
  assign col      = in_col;
  assign col_last = (EW'(in_col) + EW'(1)) >= eff_w;

  always_comb begin
    pos.emit  = (in_row >= 13'd2) || ((in_row == 13'd1) && (in_col != '0));
    pos.up    = out_row != '0;
    pos.down  = ({1'b0, out_row} + 13'd1) < {1'b0, eff_h};
    pos.left  = out_col != '0;
    pos.eor   = (EW'(out_col) + EW'(1)) >= eff_w;
    pos.right = !pos.eor;
    pos.eof   = pos.eor && !pos.down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= lhp_pkg::RESET_WIDTH;
      cfg_height <= lhp_pkg::RESET_HEIGHT;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (cfg_we) begin
      unique case (lhp_pkg::lhp_reg_t'(cfg_index))
        lhp_pkg::REG_IMAGE_WIDTH: begin
          cfg_width <= cfg_data[lhp_pkg::WIDTH_REG_W-1:0];
        end
        lhp_pkg::REG_IMAGE_HEIGHT: begin
          cfg_height <= cfg_data[lhp_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      if (pos.emit && pos.eof) begin
        // last output of the frame: restart everything
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col_last) begin
          in_col <= '0;
          in_row <= in_row + 13'd1;
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (pos.emit) begin
          if (pos.eor) begin
            out_col <= '0;
            out_row <= out_row + 12'd1;
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

endmodule

>>> sv/lhp_line_buf.sv
// ----------------------------------------------------------------------------
// Laplacian high-pass line buffers
// Two row memories; read when a beat is taken, rotate rows on the following write.
// ----------------------------------------------------------------------------
module lhp_line_buf #(
  parameter int MAX_WIDTH = lhp_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [CW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [CW-1:0]             wr_addr,
  input  logic [lhp_pkg::PIX_W-1:0] wr_pix,
  output logic [lhp_pkg::PIX_W-1:0] older_q,
  output logic [lhp_pkg::PIX_W-1:0] newer_q
);

  logic [lhp_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [lhp_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_q <= older_mem[rd_addr];
      newer_q <= newer_mem[rd_addr];
    end
  end

  // newer row moves down into the older row, the new pixel takes its place
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= newer_q;
      newer_mem[wr_addr] <= wr_pix;
    end
  end

endmodule

>>> sv/lhp_window.sv
// ----------------------------------------------------------------------------
// Laplacian high-pass window and kernel
// 3x3 pixel window and the masked center-8 / neighbor -1 sum with clamp.
// ----------------------------------------------------------------------------
module lhp_window (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [lhp_pkg::PIX_W-1:0] older_q,
  input  logic [lhp_pkg::PIX_W-1:0] newer_q,
  input  logic [lhp_pkg::PIX_W-1:0] incoming,
  input  lhp_pkg::lhp_pos_t         pos,
  output logic [lhp_pkg::PIX_W-1:0] pixel
);

  logic [lhp_pkg::PIX_W-1:0]        win [3][3];
  logic signed [lhp_pkg::SUM_W-1:0] sum;
  logic signed [lhp_pkg::SUM_W-1:0] biased;
  logic [2:0]                       row_ok;
  logic [2:0]                       col_ok;

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= older_q;
      win[1][2] <= newer_q;
      win[2][2] <= incoming;
    end
  end

  assign row_ok = {pos.down, 1'b1, pos.up};
  assign col_ok = {pos.right, 1'b1, pos.left};

  always_comb begin
    sum = $signed({2'b00, win[1][1], 3'b000});
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c]) begin
          sum = sum - $signed({5'b00000, win[r][c]});
        end
      end
    end
    biased = sum + lhp_pkg::ROUND_OFFSET;
    // a non-negative 13-bit value shifted by 4 never exceeds 255
    pixel = biased[lhp_pkg::SUM_W-1] ? '0 : biased[11:4];
  end

endmodule
